@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file tgi_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AST_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tgi_pkg.sv @@
// ----------------------------------------------------------------------------
// tgi_pkg
// Types, codes and defaults of the touch gesture interpreter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tgi_pkg;

  localparam int REGIONS_DEF    = 8;
  localparam int POLL_MS_DEF    = 20;
  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_RESULTS    = 16;

  localparam logic [3:0] EV_SWIPE_LEFT  = 4'd0;
  localparam logic [3:0] EV_SWIPE_RIGHT = 4'd1;
  localparam logic [3:0] EV_SWIPE_UP    = 4'd2;
  localparam logic [3:0] EV_SWIPE_DOWN  = 4'd3;
  localparam logic [3:0] EV_DOWN        = 4'd4;
  localparam logic [3:0] EV_HOLD        = 4'd5;
  localparam logic [3:0] EV_UP          = 4'd6;
  localparam logic [3:0] EV_LONG        = 4'd7;
  localparam logic [3:0] EV_TAP         = 4'd8;
  localparam logic [3:0] EV_ACTIVITY    = 4'd9;
  localparam logic [3:0] EV_INACTIVITY  = 4'd10;

  localparam logic [2:0] CFG_INACT_LIMIT = 3'd0;
  localparam logic [2:0] CFG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] CFG_TAP_MIN     = 3'd2;
  localparam logic [2:0] CFG_TAP_MAX     = 3'd3;
  localparam logic [2:0] CFG_SWIPE_DIST  = 3'd4;
  localparam logic [2:0] CFG_ACT_ON      = 3'd5;

  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic phase;
    logic scan;
    logic extra;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic do_scan;
    logic extra;
    logic brk;
    logic last_idx;
  } status_t;

endpackage

@@ rtl/core/tgi_ctrl.sv @@
// ----------------------------------------------------------------------------
// tgi_ctrl
// Sequencer: phase step, region scan with extra event steps, flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tgi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  tgi_pkg::status_t st,
  output tgi_pkg::cmd_t    cmd,
  output logic             busy
);
  import tgi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PHASE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EXTRA = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start && op == OP_POLL) state_next = S_PHASE;
      end
      S_PHASE: begin
        cmd.phase = 1'b1;
        state_next = st.do_scan ? S_SCAN : S_FLUSH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.extra) state_next = S_EXTRA;
        else if (st.brk || st.last_idx) state_next = S_FLUSH;
      end
      S_EXTRA: begin
        cmd.extra = 1'b1;
        state_next = st.last_idx ? S_FLUSH : S_SCAN;
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/core/tgi_dp.sv @@
// ----------------------------------------------------------------------------
// tgi_dp
// Datapath: config, region table, gesture state, event buffer and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tgi_dp #(
  parameter int REGIONS    = tgi_pkg::REGIONS_DEF,
  parameter int POLL_MS    = tgi_pkg::POLL_MS_DEF,
  parameter int COORD_BITS = tgi_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  op,
  input  logic                  touched,
  input  logic [COORD_BITS-1:0] touch_x,
  input  logic [COORD_BITS-1:0] touch_y,
  input  logic [2:0]            region_index,
  input  logic [COORD_BITS-1:0] region_left,
  input  logic [COORD_BITS-1:0] region_top,
  input  logic [COORD_BITS-1:0] region_width,
  input  logic [COORD_BITS-1:0] region_height,
  input  logic                  region_enable,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  tgi_pkg::cmd_t         cmd,
  output tgi_pkg::status_t      st,
  output logic                  strobe,
  output logic [3:0]            event_res,
  output logic [2:0]            event_region,
  output logic [COORD_BITS-1:0] event_x,
  output logic [COORD_BITS-1:0] event_y,
  output logic                  last
);
  import tgi_pkg::*;

  localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int PW = $clog2(REGIONS + 1);
  localparam int CB = COORD_BITS;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic [15:0] inact_limit, long_press, tap_min, tap_max;
  logic [11:0] swipe_dist;
  logic        act_on;

  logic [CB-1:0] rleft [REGIONS];
  logic [CB-1:0] rtop  [REGIONS];
  logic [CB-1:0] rw    [REGIONS];
  logic [CB-1:0] rh    [REGIONS];
  logic [REGIONS-1:0] ron, rpr, rlg;

  logic          active_phase;
  logic [16:0]   idle_count;
  logic [PW-1:0] pressed_count;
  logic [CB-1:0] start_x, start_y, held_x, held_y, sx, sy;
  logic [15:0]   tap_time, long_time;
  logic          st_t;
  logic [IW-1:0] idx;
  logic          extra_up;

  logic          pend_v;
  logic [3:0]    pend_res;
  logic [2:0]    pend_reg;
  logic          pend_xy;
  logic [NW-1:0] n;

  // phase step
  logic        ap_c, proc_c, inact_c, act_c, scan_c;
  logic [16:0] ic_c, lim17, lim1;
  always_comb begin
    lim17 = {1'b0, inact_limit};
    lim1 = lim17 + 17'd1;
    ap_c = active_phase;
    ic_c = idle_count;
    proc_c = 1'b0;
    inact_c = 1'b0;
    act_c = 1'b0;
    scan_c = 1'b0;
    if (ap_c && !st_t && pressed_count == '0) ap_c = 1'b0;
    if (!ap_c) begin
      if (!st_t && pressed_count == '0) begin
        if (idle_count < lim17) ic_c = idle_count + 17'd1;
        else if (idle_count == lim17) begin
          inact_c = act_on;
          ic_c = idle_count + 17'd1;
        end
      end else begin
        ic_c = (idle_count == lim1) ? 17'd0 : 17'd3;
        ap_c = 1'b1;
        proc_c = 1'b1;
      end
    end else begin
      proc_c = 1'b1;
    end
    if (proc_c) begin
      if (ic_c == 17'd0 && act_on) begin
        act_c = 1'b1;
        ic_c = 17'd2;
      end else if (ic_c != 17'd2) begin
        scan_c = 1'b1;
      end
    end
  end

  // region evaluation
  logic [CB:0]   sum_x, sum_y;
  logic          hit, on_i, pr_i, lg_i;
  logic [16:0]   tap_s, long_s;
  logic [15:0]   tap_n, long_n;
  logic signed [CB:0] dx, dy;
  logic [CB:0]   ax, ay;
  logic          rel_has, long_hit;
  logic [3:0]    rel_code;
  always_comb begin
    sum_x = {1'b0, rleft[idx]} + {1'b0, rw[idx]};
    sum_y = {1'b0, rtop[idx]} + {1'b0, rh[idx]};
    on_i = ron[idx];
    pr_i = rpr[idx];
    lg_i = rlg[idx];
    hit = st_t && (sx > rleft[idx]) && (sy > rtop[idx]) &&
          ({1'b0, sx} < sum_x) && ({1'b0, sy} < sum_y);
    tap_s = {1'b0, tap_time} + 17'(POLL_MS);
    long_s = {1'b0, long_time} + 17'(POLL_MS);
    tap_n = tap_s[16] ? 16'hFFFF : tap_s[15:0];
    long_n = long_s[16] ? 16'hFFFF : long_s[15:0];
    long_hit = !lg_i && (long_n >= long_press);
    dx = $signed({1'b0, start_x}) - $signed({1'b0, held_x});
    dy = $signed({1'b0, start_y}) - $signed({1'b0, held_y});
    ax = dx[CB] ? (CB+1)'(-dx) : (CB+1)'(dx);
    ay = dy[CB] ? (CB+1)'(-dy) : (CB+1)'(dy);
    rel_has = 1'b1;
    if (17'(ax) >= 17'(swipe_dist)) rel_code = dx[CB] ? EV_SWIPE_RIGHT : EV_SWIPE_LEFT;
    else if (17'(ay) >= 17'(swipe_dist)) rel_code = dy[CB] ? EV_SWIPE_UP : EV_SWIPE_DOWN;
    else begin
      rel_code = EV_TAP;
      rel_has = (tap_time <= tap_max) && (tap_time >= tap_min);
    end
  end

  // event of this cycle
  logic       ev_v, ev_xy;
  logic [3:0] ev_res;
  always_comb begin
    ev_v = 1'b0;
    ev_res = EV_UP;
    ev_xy = 1'b1;
    st = '0;
    st.do_scan = scan_c;
    st.last_idx = (32'(idx) == REGIONS - 1);
    if (cmd.phase) begin
      ev_v = inact_c || act_c;
      ev_res = inact_c ? EV_INACTIVITY : EV_ACTIVITY;
      ev_xy = 1'b0;
    end else if (cmd.scan && on_i) begin
      if (hit && !pr_i) begin
        ev_v = 1'b1;
        ev_res = EV_DOWN;
        st.brk = 1'b1;
      end else if (hit) begin
        ev_v = 1'b1;
        ev_res = EV_HOLD;
        st.extra = long_hit;
      end else if (pr_i) begin
        ev_v = 1'b1;
        ev_res = rel_has ? rel_code : EV_UP;
        st.extra = rel_has;
      end
    end else if (cmd.extra) begin
      ev_v = 1'b1;
      ev_res = extra_up ? EV_UP : EV_LONG;
    end
  end

  // config, region writes and gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      inact_limit <= 16'd3000;
      long_press <= 16'd1000;
      tap_min <= 16'd50;
      tap_max <= 16'd300;
      swipe_dist <= 12'd40;
      act_on <= 1'b1;
      ron <= '0;
      rpr <= '0;
      rlg <= '0;
      active_phase <= 1'b0;
      idle_count <= '0;
      pressed_count <= '0;
      start_x <= '0;
      start_y <= '0;
      held_x <= '0;
      held_y <= '0;
      tap_time <= '0;
      long_time <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INACT_LIMIT: inact_limit <= cfg_data;
          CFG_LONG_PRESS: long_press <= cfg_data;
          CFG_TAP_MIN: tap_min <= cfg_data;
          CFG_TAP_MAX: tap_max <= cfg_data;
          CFG_SWIPE_DIST: swipe_dist <= cfg_data[11:0];
          CFG_ACT_ON: act_on <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept && op == OP_WRITE && 32'(region_index) < REGIONS) begin
        rleft[IW'(region_index)] <= region_left;
        rtop[IW'(region_index)] <= region_top;
        rw[IW'(region_index)] <= region_width;
        rh[IW'(region_index)] <= region_height;
        ron[IW'(region_index)] <= region_enable;
        rpr[IW'(region_index)] <= 1'b0;
        rlg[IW'(region_index)] <= 1'b0;
        if (rpr[IW'(region_index)] && pressed_count != '0)
          pressed_count <= pressed_count - PW'(1);
      end
      if (cmd.phase) begin
        active_phase <= ap_c;
        idle_count <= ic_c;
      end
      if (cmd.scan && on_i) begin
        if (hit && !pr_i) begin
          rpr[idx] <= 1'b1;
          pressed_count <= pressed_count + PW'(1);
          long_time <= '0;
          tap_time <= '0;
          start_x <= sx;
          start_y <= sy;
        end else if (hit) begin
          held_x <= sx;
          held_y <= sy;
          tap_time <= tap_n;
          if (!lg_i) begin
            long_time <= long_n;
            if (long_hit) rlg[idx] <= 1'b1;
          end
        end else if (pr_i) begin
          rlg[idx] <= 1'b0;
          rpr[idx] <= 1'b0;
          if (pressed_count != '0) pressed_count <= pressed_count - PW'(1);
        end
      end
    end
  end

  // sample latch and scan index
  always_ff @(posedge clk) begin
    if (accept) begin
      st_t <= touched;
      sx <= touch_x;
      sy <= touch_y;
      idx <= '0;
    end
    if (cmd.scan) begin
      extra_up <= !hit;
      if (!st.extra) idx <= idx + IW'(1);
    end
    if (cmd.extra) idx <= idx + IW'(1);
  end

  // one-beat holding buffer so the final beat can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      strobe <= 1'b0;
      n <= '0;
    end else begin
      strobe <= 1'b0;
      if (accept) n <= '0;
      if (ev_v && n < NW'(MAX_RESULTS)) begin
        n <= n + NW'(1);
        pend_v <= 1'b1;
        pend_res <= ev_res;
        pend_reg <= ev_xy ? 3'(idx) : 3'd0;
        pend_xy <= ev_xy;
        if (pend_v) begin
          strobe <= 1'b1;
          last <= 1'b0;
          event_res <= pend_res;
          event_region <= pend_reg;
          event_x <= pend_xy ? sx : '0;
          event_y <= pend_xy ? sy : '0;
        end
      end
      if (cmd.flush && pend_v) begin
        pend_v <= 1'b0;
        strobe <= 1'b1;
        last <= 1'b1;
        event_res <= pend_res;
        event_region <= pend_reg;
        event_x <= pend_xy ? sx : '0;
        event_y <= pend_xy ? sy : '0;
      end
    end
  end

endmodule

@@ rtl/core/touch_gesture_interpreter.sv @@
// ----------------------------------------------------------------------------
// touch_gesture_interpreter
// Turns touch poll samples into key, gesture and activity events on a
// table of rectangular regions.
//
//   channel  handshake          payload
//   input    start / busy       op, touched, touch_x/y, region_*
//   result   strobe (one beat)  event_res, event_region, event_x/y, last
//   config   cfg_we             cfg_index, cfg_data
//
// Region writes leave busy low. A poll sample runs a phase step, a scan
// step per scanned region, an extra step after each long press, swipe or
// tap, and a flush step; the scan takes one region a cycle unless an
// extra step holds it. Each beat waits in a one-beat buffer until the
// next event or the flush step, so the final beat leaves in the cycle
// after the flush. Reset is synchronous; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module touch_gesture_interpreter #(
  parameter int REGIONS    = tgi_pkg::REGIONS_DEF,
  parameter int POLL_MS    = tgi_pkg::POLL_MS_DEF,
  parameter int COORD_BITS = tgi_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op,
  input  logic                  touched,
  input  logic [COORD_BITS-1:0] touch_x,
  input  logic [COORD_BITS-1:0] touch_y,
  input  logic [2:0]            region_index,
  input  logic [COORD_BITS-1:0] region_left,
  input  logic [COORD_BITS-1:0] region_top,
  input  logic [COORD_BITS-1:0] region_width,
  input  logic [COORD_BITS-1:0] region_height,
  input  logic                  region_enable,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  strobe,
  output logic [3:0]            event_res,
  output logic [2:0]            event_region,
  output logic [COORD_BITS-1:0] event_x,
  output logic [COORD_BITS-1:0] event_y,
  output logic                  last
);
  import tgi_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    accept;

  assign accept = start && !busy;

  tgi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op), .st(st), .cmd(cmd), .busy(busy)
  );

  tgi_dp #(.REGIONS(REGIONS), .POLL_MS(POLL_MS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst(rst), .accept(accept), .op(op), .touched(touched),
    .touch_x(touch_x), .touch_y(touch_y), .region_index(region_index),
    .region_left(region_left), .region_top(region_top),
    .region_width(region_width), .region_height(region_height),
    .region_enable(region_enable), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .st(st), .strobe(strobe),
    .event_res(event_res), .event_region(event_region), .event_x(event_x),
    .event_y(event_y), .last(last)
  );

endmodule

@@ rtl/core/tgi_checker.sv @@
// ----------------------------------------------------------------------------
// tgi_checker
// Port-level checks of the touch gesture interpreter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tgi_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       op,
  input logic       strobe,
  input logic [3:0] event_res
);
  import tgi_pkg::*;

  `AST_NXT(a_rst_quiet, rst, !strobe && !busy, "beat or busy right after reset")
  `AST_NXT(a_write_1cy, !rst && start && !busy && op == OP_WRITE, !busy, "region write held busy")
  `AST_NXT(a_poll_busy, !rst && start && !busy && op == OP_POLL, busy, "poll sample not taken")
  `AST_IMP(a_code_range, !rst && strobe, event_res <= EV_INACTIVITY, "event code out of range")

endmodule

bind touch_gesture_interpreter tgi_checker u_tgi_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
  .strobe(strobe), .event_res(event_res)
);
